// File: rtl/plist_pkg.sv
// Shared types, field widths and codes for the positional list core.
package plist_pkg;

	// Field widths of the command and response transfers.
	localparam int MODE_W   = 3;
	localparam int POS_W    = 9;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef logic [MODE_W-1:0] mode_t;

	// Command codes; the two remaining codes are no-ops.
	localparam mode_t MODE_INS_FRONT = 3'd0;
	localparam mode_t MODE_INS_END   = 3'd1;
	localparam mode_t MODE_INS_POS   = 3'd2;
	localparam mode_t MODE_REM_FRONT = 3'd3;
	localparam mode_t MODE_REM_END   = 3'd4;
	localparam mode_t MODE_REM_POS   = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_TAKE_RD,
		S_TAKE,
		S_MOV_RD,
		S_MOV_WR,
		S_PUT,
		S_DONE
	} state_t;

endpackage

// File: rtl/plist_cmd_if.sv
// Command channel: valid/ready handshake with the list command payload.
interface plist_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [plist_pkg::MODE_W-1:0]   mode;
	logic [plist_pkg::POS_W-1:0]    position;
	logic [plist_pkg::HANDLE_W-1:0] record_handle;

	modport source (output valid, output mode, output position, output record_handle,
		input ready);
	modport sink (input valid, input mode, input position, input record_handle,
		output ready);
endinterface

// File: rtl/plist_rsp_if.sv
// Response channel: valid/ready handshake with the list response payload.
interface plist_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [plist_pkg::HANDLE_W-1:0] removed_handle;
	logic [plist_pkg::STATUS_W-1:0] status;
	logic [plist_pkg::COUNT_W-1:0]  entry_count;

	modport source (output valid, output removed_handle, output status,
		output entry_count, input ready);
	modport sink (input valid, input removed_handle, input status,
		input entry_count, output ready);
endinterface

// File: rtl/plist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module plist_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/positional_list_insert_remove_core.sv
// Positional list core: keeps up to CAPACITY record handles densely packed in one RAM and
// carries out insert and remove commands at the front, at the end or at a given position,
// answering each command transfer with one response transfer that holds the removed handle
// (zero unless a remove succeeded), a status code and the entry count after the command.
// The entries behind the affected slot are moved one place at a time by a small sequencer
// around the single RAM, which has one write and one registered read port; every moved
// entry is read in S_MOV_RD and written in S_MOV_WR. A new command is accepted only in
// S_IDLE, once the previous response has been registered. The number of entries that
// move is count minus position for an insert and count minus position minus one for a
// remove, and none for a rejected command or an unused mode code. So a push at the end or
// a pop at the end moves no entry, while working at the front of a full list moves nearly
// all of them. A full list, an empty list or a bad position is reported in the status and
// leaves the list untouched. No clearing pass runs after reset: only slots below the entry
// count are ever read, and those have all been written.
module positional_list_insert_remove_core #(
	parameter int CAPACITY     = 256,
	parameter int HANDLE_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	plist_cmd_if.sink   cmd,
	plist_rsp_if.source rsp
);

	// Slot address, entry count, and a compare width that holds both count and position.
	localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;
	localparam int HW_EXT = (HANDLE_WIDTH > plist_pkg::HANDLE_W) ? HANDLE_WIDTH
		: plist_pkg::HANDLE_W;
	localparam int CNT_EXT = (CNT_W > plist_pkg::COUNT_W) ? CNT_W : plist_pkg::COUNT_W;

	plist_pkg::state_t state_q, state_d;

	// Command held for the duration of its processing.
	plist_pkg::mode_t          mode_q;
	logic [plist_pkg::POS_W-1:0] pos_q;
	logic [HANDLE_WIDTH-1:0]   handle_q;

	// List state and the sequencer's working registers.
	logic [CNT_W-1:0]          occ_q;
	logic [AW-1:0]             at_q;
	logic [AW-1:0]             cursor_q;
	logic [AW-1:0]             limit_q;
	plist_pkg::op_t            op_q;
	plist_pkg::status_t        status_q;
	logic [HANDLE_WIDTH-1:0]   taken_q;

	// Response register.
	logic                           rsp_valid_q;
	logic [plist_pkg::HANDLE_W-1:0] rsp_removed_q;
	logic [plist_pkg::STATUS_W-1:0] rsp_status_q;
	logic [plist_pkg::COUNT_W-1:0]  rsp_count_q;

	// Decision made from the held command and the current count.
	plist_pkg::op_t     dec_op;
	plist_pkg::status_t dec_status;
	logic [AW-1:0]      dec_at;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   occ_ext;
	logic [CNT_W-1:0]   occ_dec;
	logic               list_full;
	logic               list_empty;

	// Shared step unit: the neighbor slot of the cursor and the end-of-move compare.
	logic [AW-1:0] nbr;
	logic          move_done;

	logic                    ram_wr_en;
	logic [AW-1:0]           ram_wr_addr;
	logic [HANDLE_WIDTH-1:0] ram_wr_data;
	logic                    ram_rd_en;
	logic [AW-1:0]           ram_rd_addr;
	logic [HANDLE_WIDTH-1:0] ram_rd_data;

	logic                    cmd_fire;
	logic                    rsp_free;
	logic [CNT_W-1:0]        occ_new;
	logic [CNT_EXT-1:0]      occ_new_ext;
	logic [HW_EXT-1:0]       handle_in_ext;
	logic [HW_EXT-1:0]       taken_ext;

	assign cmd.ready  = (state_q == plist_pkg::S_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign rsp_free   = !rsp_valid_q || rsp.ready;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.removed_handle = rsp_removed_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.entry_count    = rsp_count_q;

	// Handles are stored at HANDLE_WIDTH bits and reported at the port width.
	assign handle_in_ext = HW_EXT'(cmd.record_handle);
	assign taken_ext     = HW_EXT'(taken_q);

	assign pos_ext    = CMP_W'(pos_q);
	assign occ_ext    = CMP_W'(occ_q);
	assign occ_dec    = occ_q - 1'b1;
	assign list_full  = (occ_q == CNT_W'(CAPACITY));
	assign list_empty = (occ_q == '0);

	// The full and empty checks come before the position check.
	always_comb begin
		dec_op     = plist_pkg::OP_NONE;
		dec_status = plist_pkg::ST_OK;
		dec_at     = '0;
		case (mode_q)
			plist_pkg::MODE_INS_FRONT: begin
				if (list_full) begin
					dec_status = plist_pkg::ST_FULL;
				end else begin
					dec_op = plist_pkg::OP_INSERT;
				end
			end
			plist_pkg::MODE_INS_END: begin
				if (list_full) begin
					dec_status = plist_pkg::ST_FULL;
				end else begin
					dec_op = plist_pkg::OP_INSERT;
					dec_at = occ_q[AW-1:0];
				end
			end
			plist_pkg::MODE_INS_POS: begin
				if (list_full) begin
					dec_status = plist_pkg::ST_FULL;
				end else if (pos_ext > occ_ext) begin
					dec_status = plist_pkg::ST_RANGE;
				end else begin
					dec_op = plist_pkg::OP_INSERT;
					dec_at = pos_ext[AW-1:0];
				end
			end
			plist_pkg::MODE_REM_FRONT: begin
				if (list_empty) begin
					dec_status = plist_pkg::ST_EMPTY;
				end else begin
					dec_op = plist_pkg::OP_REMOVE;
				end
			end
			plist_pkg::MODE_REM_END: begin
				if (list_empty) begin
					dec_status = plist_pkg::ST_EMPTY;
				end else begin
					dec_op = plist_pkg::OP_REMOVE;
					dec_at = occ_dec[AW-1:0];
				end
			end
			plist_pkg::MODE_REM_POS: begin
				if (list_empty) begin
					dec_status = plist_pkg::ST_EMPTY;
				end else if (pos_ext >= occ_ext) begin
					dec_status = plist_pkg::ST_RANGE;
				end else begin
					dec_op = plist_pkg::OP_REMOVE;
					dec_at = pos_ext[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// An insert walks the cursor down toward the gap, a remove walks it up from the hole.
	assign nbr       = (op_q == plist_pkg::OP_INSERT) ? (cursor_q - 1'b1) : (cursor_q + 1'b1);
	assign move_done = (cursor_q == limit_q);

	always_comb begin
		case (op_q)
			plist_pkg::OP_INSERT: occ_new = occ_q + 1'b1;
			plist_pkg::OP_REMOVE: occ_new = occ_dec;
			default:              occ_new = occ_q;
		endcase
	end
	assign occ_new_ext = CNT_EXT'(occ_new);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			plist_pkg::S_IDLE: begin
				if (cmd_fire) begin
					state_d = plist_pkg::S_DECIDE;
				end
			end
			plist_pkg::S_DECIDE: begin
				case (dec_op)
					plist_pkg::OP_INSERT: state_d = plist_pkg::S_MOV_RD;
					plist_pkg::OP_REMOVE: state_d = plist_pkg::S_TAKE_RD;
					default:              state_d = plist_pkg::S_DONE;
				endcase
			end
			plist_pkg::S_TAKE_RD: state_d = plist_pkg::S_TAKE;
			plist_pkg::S_TAKE:    state_d = plist_pkg::S_MOV_RD;
			plist_pkg::S_MOV_RD: begin
				if (!move_done) begin
					state_d = plist_pkg::S_MOV_WR;
				end else if (op_q == plist_pkg::OP_INSERT) begin
					state_d = plist_pkg::S_PUT;
				end else begin
					state_d = plist_pkg::S_DONE;
				end
			end
			plist_pkg::S_MOV_WR:  state_d = plist_pkg::S_MOV_RD;
			plist_pkg::S_PUT:     state_d = plist_pkg::S_DONE;
			plist_pkg::S_DONE: begin
				if (rsp_free) begin
					state_d = plist_pkg::S_IDLE;
				end
			end
			default: state_d = plist_pkg::S_IDLE;
		endcase
	end

	// RAM controls per state.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = cursor_q;
		ram_wr_data = ram_rd_data;
		ram_rd_en   = 1'b0;
		ram_rd_addr = nbr;
		case (state_q)
			plist_pkg::S_TAKE_RD: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = at_q;
			end
			plist_pkg::S_MOV_RD: begin
				ram_rd_en = !move_done;
			end
			plist_pkg::S_MOV_WR: begin
				ram_wr_en = 1'b1;
			end
			plist_pkg::S_PUT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = at_q;
				ram_wr_data = handle_q;
			end
			default: begin
			end
		endcase
	end

	plist_ram #(
		.WIDTH (HANDLE_WIDTH),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plist_pkg::S_IDLE;
			occ_q       <= '0;
			op_q        <= plist_pkg::OP_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plist_pkg::S_DECIDE) begin
				op_q <= dec_op;
			end
			if (state_q == plist_pkg::S_DONE && rsp_free) begin
				occ_q       <= occ_new;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			mode_q   <= cmd.mode;
			pos_q    <= cmd.position;
			handle_q <= handle_in_ext[HANDLE_WIDTH-1:0];
		end
		case (state_q)
			plist_pkg::S_DECIDE: begin
				status_q <= dec_status;
				at_q     <= dec_at;
				taken_q  <= '0;
				if (dec_op == plist_pkg::OP_INSERT) begin
					cursor_q <= occ_q[AW-1:0];
					limit_q  <= dec_at;
				end else begin
					cursor_q <= dec_at;
					limit_q  <= occ_dec[AW-1:0];
				end
			end
			plist_pkg::S_TAKE: begin
				taken_q <= ram_rd_data;
			end
			plist_pkg::S_MOV_WR: begin
				cursor_q <= nbr;
			end
			plist_pkg::S_DONE: begin
				if (rsp_free) begin
					rsp_removed_q <= taken_ext[plist_pkg::HANDLE_W-1:0];
					rsp_status_q  <= status_q;
					rsp_count_q   <= occ_new_ext[plist_pkg::COUNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// The entry count never goes past the capacity.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The count moves by at most one per command.
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |->
			(occ_q == $past(occ_q) + 1'b1 || occ_q == $past(occ_q) - 1'b1))
		else $error("entry count jumped by more than one");

	// A new response only comes out of the final sequencer step.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == plist_pkg::S_DONE))
		else $error("response raised outside the final step");

	// A move write never happens once the cursor has reached its limit.
	a_move_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plist_pkg::S_MOV_WR) |-> !move_done)
		else $error("slot move past its limit");

	// An accepted command is decided in the following cycle.
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q == plist_pkg::S_DECIDE))
		else $error("accepted command not decided");

endmodule

// File: test/plist_response_checker.sv
// Response checker for the positional list core: predicts every response and compares it.
module plist_response_checker
	import plist_pkg::*;
#(
	parameter int CAPACITY     = 256,
	parameter int HANDLE_WIDTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	plist_cmd_if  cmd_mon,
	plist_rsp_if  rsp_mon,
	output int    failures,
	output int    outstanding,
	output int    predicted_count
);

	typedef struct packed {
		logic [HANDLE_W-1:0] removed_handle;
		status_t             status;
		logic [COUNT_W-1:0]  entry_count;
	} list_response_t;

	logic [HANDLE_WIDTH-1:0] list_slots [CAPACITY];
	int                      held;
	list_response_t          awaited_responses [$];
	list_response_t          want;
	int                      fail_tally;

	// Applies one command to the shadow list and returns the response it must produce.
	function automatic list_response_t apply_list_command(input mode_t m,
		input logic [POS_W-1:0] p, input logic [HANDLE_W-1:0] h);
		list_response_t r;
		int at;
		int i;
		r.removed_handle = '0;
		r.status         = ST_OK;
		at               = -1;
		case (m)
			MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
				if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					if (m == MODE_INS_FRONT)
						at = 0;
					else if (m == MODE_INS_END)
						at = held;
					else if (int'(p) <= held)
						at = int'(p);
					if (at < 0) begin
						r.status = ST_RANGE;
					end else begin
						for (i = held; i > at; i--)
							list_slots[i] = list_slots[i-1];
						list_slots[at] = h[HANDLE_WIDTH-1:0];
						held++;
					end
				end
			end
			MODE_REM_FRONT, MODE_REM_END, MODE_REM_POS: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (m == MODE_REM_FRONT)
						at = 0;
					else if (m == MODE_REM_END)
						at = held - 1;
					else if (int'(p) < held)
						at = int'(p);
					if (at < 0) begin
						r.status = ST_RANGE;
					end else begin
						r.removed_handle = HANDLE_W'(list_slots[at]);
						for (i = at; i + 1 < held; i++)
							list_slots[i] = list_slots[i+1];
						held--;
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = COUNT_W'(held);
		return r;
	endfunction

	function automatic void flag_failure();
		fail_tally++;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			awaited_responses.delete();
			held            = 0;
			fail_tally      = 0;
			failures        <= 0;
			outstanding     <= 0;
			predicted_count <= 0;
		end else begin
			if (cmd_mon.valid && cmd_mon.ready)
				awaited_responses.push_back(apply_list_command(mode_t'(cmd_mon.mode),
					cmd_mon.position, cmd_mon.record_handle));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (awaited_responses.size() == 0) begin
					if (fail_tally < 10)
						$display("unexpected response: handle %h status %0d count %0d",
							rsp_mon.removed_handle, rsp_mon.status, rsp_mon.entry_count);
					flag_failure();
				end else begin
					want = awaited_responses.pop_front();
					if (rsp_mon.removed_handle !== want.removed_handle ||
						rsp_mon.status !== want.status ||
						rsp_mon.entry_count !== want.entry_count) begin
						if (fail_tally < 10)
							$display("mismatch: expected handle %h status %0d count %0d, got handle %h status %0d count %0d",
								want.removed_handle, want.status, want.entry_count,
								rsp_mon.removed_handle, rsp_mon.status, rsp_mon.entry_count);
						flag_failure();
					end
				end
			end
			failures        <= fail_tally;
			outstanding     <= awaited_responses.size();
			predicted_count <= held;
		end
	end

endmodule

// File: test/positional_list_insert_remove_core_test.sv
// Testbench top for the positional list core: clock, reset, command stimulus and verdict.
module positional_list_insert_remove_core_test;
	import plist_pkg::*;

	localparam int CAPACITY     = 256;
	localparam int HANDLE_WIDTH = 16;

	// The two mode codes that the block treats as no-ops.
	localparam mode_t MODE_SPARE_LO = 3'd6;
	localparam mode_t MODE_SPARE_HI = 3'd7;

	// The slowest legal command moves nearly the whole store and also waits out both idling
	// draws, so a few thousand items fit well inside this bound, taken several times over.
	localparam int CYCLE_LIMIT  = 5000000;
	localparam int TOTAL_ITEMS  = 1750;
	localparam int SETTLE_WAIT  = 32;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	plist_cmd_if cmd_bus ();
	plist_rsp_if rsp_bus ();

	int failures;
	int outstanding;
	int predicted_count;
	int cycle_count = 0;
	int items_sent  = 0;

	// Per-phase switches that turn idling off on either side to get back-to-back transfers.
	bit eager_sender   = 1'b0;
	bit eager_receiver = 1'b0;

	positional_list_insert_remove_core #(
		.CAPACITY     (CAPACITY),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	plist_response_checker #(
		.CAPACITY     (CAPACITY),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) response_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_mon         (cmd_bus),
		.rsp_mon         (rsp_bus),
		.failures        (failures),
		.outstanding     (outstanding),
		.predicted_count (predicted_count)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Response side. After each accepted response transfer the receiver draws a random
	// stall with ready low; the stall also runs while no response is pending, so ready is
	// low at every phase of the block's sequencing at one time or another.
	initial begin : response_ready_driver
		int hold;
		hold          = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				hold = 0;
				rsp_bus.ready <= 1'b0;
			end else begin
				if (rsp_bus.valid && rsp_bus.ready)
					hold = eager_receiver ? 0 : $urandom_range(0, 4);
				else if (hold > 0)
					hold--;
				rsp_bus.ready <= (hold == 0);
			end
		end
	end

	// Drives one command transfer. The caller is always at a rising edge. A nonzero gap
	// drops valid first; with no gap valid simply stays high into the next transfer, so
	// valid never gets two assignments in one step.
	task automatic send_command(input mode_t m, input logic [POS_W-1:0] p,
		input logic [HANDLE_W-1:0] h);
		int gap;
		gap = eager_sender ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid         <= 1'b1;
		cmd_bus.mode          <= m;
		cmd_bus.position      <= p;
		cmd_bus.record_handle <= h;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		items_sent++;
	endtask

	// Stops sending and waits until every predicted response has been taken. The count
	// from the checker is only exact after such a pause.
	task automatic wait_list_idle();
		cmd_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	function automatic logic [HANDLE_W-1:0] draw_handle();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return HANDLE_W'($urandom_range(0, 65535));
	endfunction

	// One random command steered toward a target fill level. Most positions are legal
	// for the current count, some sit exactly on the boundary, and the rest are noise
	// over the whole field. The count can lag by a transfer or two when there are no gaps,
	// which only shifts the mix slightly.
	task automatic send_random_item(input int target);
		int              cnt;
		int              roll;
		bit              grow;
		mode_t           m;
		logic [POS_W-1:0] p;
		cnt  = predicted_count;
		roll = $urandom_range(0, 99);
		grow = ($urandom_range(0, 99) < ((cnt < target) ? 70 : 30));
		if (roll < 4) begin
			m = (roll < 2) ? MODE_SPARE_LO : MODE_SPARE_HI;
		end else begin
			case ($urandom_range(0, 3))
				0:       m = grow ? MODE_INS_FRONT : MODE_REM_FRONT;
				1:       m = grow ? MODE_INS_END : MODE_REM_END;
				default: m = grow ? MODE_INS_POS : MODE_REM_POS;
			endcase
		end
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			if (grow)
				p = POS_W'($urandom_range(0, cnt));
			else
				p = (cnt == 0) ? '0 : POS_W'($urandom_range(0, cnt - 1));
		end else if (roll < 90) begin
			p = POS_W'(cnt);
		end else begin
			p = POS_W'($urandom_range(0, 511));
		end
		send_command(m, p, draw_handle());
	endtask

	initial begin : stimulus
		int target;
		int roll;

		cmd_bus.valid         = 1'b0;
		cmd_bus.mode          = MODE_INS_FRONT;
		cmd_bus.position      = '0;
		cmd_bus.record_handle = '0;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every mode, the removes on an empty list, the empty and range checks,
		// the boundary positions, both no-op codes, and draining the list back to empty.
		send_command(MODE_REM_FRONT, 9'd0, 16'hFFFF);
		send_command(MODE_REM_END, 9'd0, 16'h0000);
		send_command(MODE_REM_POS, 9'd0, 16'h1111);
		send_command(MODE_REM_POS, 9'd511, 16'hFFFF);
		send_command(MODE_INS_POS, 9'd1, 16'h2222);
		send_command(MODE_INS_POS, 9'd0, 16'hFFFF);
		send_command(MODE_INS_FRONT, 9'd511, 16'h0000);
		send_command(MODE_INS_END, 9'd0, 16'hA5A5);
		send_command(MODE_INS_POS, 9'd3, 16'h5A5A);
		send_command(MODE_INS_POS, 9'd5, 16'h3333);
		send_command(MODE_INS_POS, 9'd511, 16'h4444);
		send_command(MODE_INS_POS, 9'd2, 16'h1234);
		send_command(MODE_SPARE_LO, 9'd511, 16'hFFFF);
		send_command(MODE_SPARE_HI, 9'd0, 16'h0000);
		send_command(MODE_REM_POS, 9'd5, 16'h0000);
		send_command(MODE_REM_POS, 9'd256, 16'h0000);
		send_command(MODE_REM_POS, 9'd4, 16'hFFFF);
		send_command(MODE_REM_POS, 9'd1, 16'h0000);
		send_command(MODE_REM_FRONT, 9'd0, 16'h0000);
		send_command(MODE_REM_END, 9'd0, 16'h0000);
		send_command(MODE_REM_POS, 9'd0, 16'h0000);
		send_command(MODE_REM_END, 9'd0, 16'h0000);
		send_command(MODE_INS_END, 9'd0, 16'h8001);
		send_command(MODE_REM_FRONT, 9'd0, 16'h0000);
		wait_list_idle();

		// Fill to capacity with cheap appends; a lagging count may add a rejected insert
		// or two, which is harmless.
		while (predicted_count < CAPACITY)
			send_command(MODE_INS_END, POS_W'($urandom_range(0, 511)), draw_handle());
		wait_list_idle();

		// Full list: every insert on the full list is refused before its position is looked at,
		// and the positions around the top slot are tried in both directions.
		send_command(MODE_INS_FRONT, 9'd0, 16'hDEAD);
		send_command(MODE_INS_END, 9'd0, 16'hBEEF);
		send_command(MODE_INS_POS, 9'd0, 16'hCAFE);
		send_command(MODE_INS_POS, 9'd256, 16'hF00D);
		send_command(MODE_INS_POS, 9'd511, 16'hFFFF);
		send_command(MODE_REM_POS, 9'd256, 16'h0000);
		send_command(MODE_REM_POS, 9'd511, 16'h0000);
		send_command(MODE_REM_POS, 9'd255, 16'h0000);
		send_command(MODE_INS_POS, 9'd256, 16'h7777);
		send_command(MODE_INS_POS, 9'd255, 16'h8888);
		send_command(MODE_REM_FRONT, 9'd0, 16'h0000);
		send_command(MODE_INS_FRONT, 9'd0, 16'h9999);
		send_command(MODE_REM_END, 9'd0, 16'h0000);
		send_command(MODE_INS_END, 9'd0, 16'hAAAA);
		wait_list_idle();

		// Shrink back down, mostly from the end where it is cheap.
		while (predicted_count > 4) begin
			if ($urandom_range(0, 9) == 0)
				send_command(MODE_REM_FRONT, POS_W'($urandom_range(0, 511)), draw_handle());
			else
				send_command(MODE_REM_END, POS_W'($urandom_range(0, 511)), draw_handle());
		end

		// Random phases. Most hover at small fill levels where commands are fast; some go
		// to the middle, a few to the full end where front work moves the whole store.
		while (items_sent < TOTAL_ITEMS) begin
			eager_sender   = ($urandom_range(0, 3) == 0);
			eager_receiver = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 9);
			if (roll < 7)
				target = $urandom_range(0, 24);
			else if (roll < 9)
				target = $urandom_range(25, 120);
			else
				target = $urandom_range(230, CAPACITY);
			repeat ($urandom_range(20, 60))
				send_random_item(target);
			if ($urandom_range(0, 4) == 0)
				wait_list_idle();
		end

		// Let everything drain, then give a stray response a chance to show up.
		eager_receiver = 1'b0;
		wait_list_idle();
		repeat (SETTLE_WAIT) @(posedge clk);

		if (failures == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/plist_pkg.sv
rtl/plist_cmd_if.sv
rtl/plist_rsp_if.sv
rtl/plist_ram.sv
rtl/positional_list_insert_remove_core.sv
test/plist_response_checker.sv
test/positional_list_insert_remove_core_test.sv
